FILE: design/c3cd_pkg.sv
// Shared types, constants and helpers of the 3x3 convolution clamp/divide block.
package c3cd_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned RowW  = 24;
  localparam int unsigned PsumW = 20;
  localparam int unsigned DsumW = 12;
  localparam int unsigned MagW  = 11;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgWidth = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKern0 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKern1 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKern2 = 3'd4;

  localparam logic [10:0]     WidthRst = 11'd1024;
  localparam logic [15:0]     HeightRst = 16'd1024;
  localparam logic [RowW-1:0] Kern0Rst = 24'd65280;
  localparam logic [RowW-1:0] Kern1Rst = 24'd16713215;
  localparam logic [RowW-1:0] Kern2Rst = 24'd65280;

  typedef logic signed [PsumW-1:0] psum_t;

  typedef struct packed {
    logic             start;
    logic [PixW-1:0]  dividend;
    logic [MagW-1:0]  divisor;
    logic             negate;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [PixW-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [DsumW-1:0] row_coef_sum(input logic [RowW-1:0] row);
    logic signed [DsumW-1:0] acc;
    acc = DsumW'($signed(row[7:0])) + DsumW'($signed(row[15:8]))
        + DsumW'($signed(row[23:16]));
    return acc;
  endfunction

endpackage

FILE: design/c3cd_row_cell.sv
// One window row: three taps, its coefficient products and the chained partial sum.
module c3cd_row_cell
  import c3cd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic [PixW-1:0] tap_i,
  input  logic [RowW-1:0] coef_i,
  input  logic            sum_i,
  input  psum_t           psum_i,
  output psum_t           psum_o
);

  logic [PixW-1:0] taps_q [3];
  psum_t           psum_q;
  psum_t           prod_sum;

  always_comb begin
    prod_sum = psum_t'($signed({1'b0, taps_q[0]}) * $signed(coef_i[7:0]))
             + psum_t'($signed({1'b0, taps_q[1]}) * $signed(coef_i[15:8]))
             + psum_t'($signed({1'b0, taps_q[2]}) * $signed(coef_i[23:16]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q[0] <= '0;
      taps_q[1] <= '0;
      taps_q[2] <= '0;
    end else if (shift_i) begin
      taps_q[0] <= taps_q[1];
      taps_q[1] <= taps_q[2];
      taps_q[2] <= tap_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_i) begin
      psum_q <= psum_i + prod_sum;
    end
  end

  assign psum_o = psum_q;

endmodule

FILE: design/c3cd_div.sv
// Iterative restoring divider, one quotient bit per cycle, signed result.
module c3cd_div
  import c3cd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic            busy_q;
  logic [2:0]      cnt_q;
  logic [PixW-1:0] num_q;
  logic [PixW-1:0] quo_q;
  logic [MagW:0]   rem_q;
  logic [MagW-1:0] den_q;
  logic            neg_q;
  logic            done_q;
  logic [MagW:0]   rem_sh;
  logic            fits;

  assign rem_sh = {rem_q[MagW-1:0], num_q[PixW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      neg_q <= req_i.negate;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[PixW-2:0], 1'b0};
      rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_q <= {quo_q[PixW-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (~quo_q + 8'd1) : quo_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");
`endif

endmodule

FILE: design/conv3x3_clamp_divide_unit.sv
// Top level of the 3x3 convolution with clamp and coefficient-sum divide.
//   channel | signals                                   | direction
//   pixel   | in_valid_i in_ready_o pixel_i frame_start_i | in
//   result  | out_valid_o out_ready_i filtered_o div_zero_o frame_end_o | out
//   config  | cfg_we_i cfg_idx_i cfg_data_i             | in
// One pixel at a time: a border pixel passes IDLE and READ only; an interior pixel
// also passes the three-cell sum chain (SUM), CLAMP, the 8-step divider unless the
// coefficient sum is zero, and DONE. Line stores are read at accept.
// Reset clears counters, window and control; line stores are not cleared.
// A result waiting in the output register stalls only the final step.
module conv3x3_clamp_divide_unit
  import c3cd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PixW-1:0]    pixel_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PixW-1:0]    filtered_o,
  output logic               div_zero_o,
  output logic               frame_end_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RowW-1:0]    cfg_data_i
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW = (WW > 11) ? WW : 11;
  localparam logic [EW-1:0] MaxW = EW'(MAX_WIDTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_CLAMP = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [10:0]     width_q;
  logic [15:0]     height_q;
  logic [RowW-1:0] kern_q [3];

  logic [2:0]      state_q, state_d;
  logic [AW-1:0]   col_q;
  logic [15:0]     row_q;
  logic [AW-1:0]   addr_q;
  logic [PixW-1:0] px_q;
  logic            fend_q;
  logic            emit_q;
  logic [1:0]      cnt_q;
  logic [PixW-1:0] res_q;
  logic            dz_q;
  logic            out_valid_q;
  logic [PixW-1:0] out_pix_q;
  logic            out_dz_q;
  logic            out_fe_q;

  logic [PixW-1:0] mem_a [MAX_WIDTH];
  logic [PixW-1:0] mem_b [MAX_WIDTH];
  logic [PixW-1:0] a_rd_q, b_rd_q;

  logic [EW-1:0]   eff_w, c0, c1, cn;
  logic [15:0]     eff_h, r0, r1, rn;
  logic            emit, fend, acc;

  psum_t           psum [3];
  psum_t           total;
  logic [PixW-1:0] clamped;
  logic signed [DsumW-1:0] dsum, dneg;
  div_req_t        dreq;
  div_rsp_t        drsp;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    eff_w = EW'(width_q);
    if (eff_w < EW'(3)) eff_w = EW'(3);
    if (eff_w > MaxW) eff_w = MaxW;
    eff_h = (height_q < 16'd3) ? 16'd3 : height_q;

    c0 = frame_start_i ? '0 : EW'(col_q);
    r0 = frame_start_i ? '0 : row_q;
    c1 = c0;
    r1 = r0;
    if (c0 >= eff_w) begin
      c1 = '0;
      r1 = r0 + 16'd1;
    end
    if (r1 >= eff_h) r1 = '0;
    emit = (r1 >= 16'd2) && (c1 >= EW'(2));
    fend = (r1 == eff_h - 16'd1) && (c1 == eff_w - EW'(1));
    cn = c1 + EW'(1);
    rn = r1;
    if (cn >= eff_w) begin
      cn = '0;
      rn = r1 + 16'd1;
      if (rn >= eff_h) rn = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidthRst;
      height_q  <= HeightRst;
      kern_q[0] <= Kern0Rst;
      kern_q[1] <= Kern1Rst;
      kern_q[2] <= Kern2Rst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWidth:  width_q   <= cfg_data_i[10:0];
        CfgHeight: height_q  <= cfg_data_i[15:0];
        CfgKern0:  kern_q[0] <= cfg_data_i;
        CfgKern1:  kern_q[1] <= cfg_data_i;
        CfgKern2:  kern_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // line stores: read at accept, written back in the READ state that follows
  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_rd_q <= mem_a[c1[AW-1:0]];
      b_rd_q <= mem_b[c1[AW-1:0]];
    end
    if (state_q == S_READ) begin
      mem_a[addr_q] <= px_q;
      mem_b[addr_q] <= a_rd_q;
    end
  end

  c3cd_row_cell u_cell0 (
    .clk_i, .rst_ni, .shift_i(state_q == S_READ), .tap_i(b_rd_q), .coef_i(kern_q[0]),
    .sum_i(state_q == S_SUM), .psum_i('0), .psum_o(psum[0])
  );
  c3cd_row_cell u_cell1 (
    .clk_i, .rst_ni, .shift_i(state_q == S_READ), .tap_i(a_rd_q), .coef_i(kern_q[1]),
    .sum_i(state_q == S_SUM), .psum_i(psum[0]), .psum_o(psum[1])
  );
  c3cd_row_cell u_cell2 (
    .clk_i, .rst_ni, .shift_i(state_q == S_READ), .tap_i(px_q), .coef_i(kern_q[2]),
    .sum_i(state_q == S_SUM), .psum_i(psum[1]), .psum_o(psum[2])
  );

  always_comb begin
    total = psum[2];
    if (total > psum_t'(255)) clamped = 8'd255;
    else if (total < psum_t'(0)) clamped = 8'd0;
    else clamped = total[PixW-1:0];
    dsum = row_coef_sum(kern_q[0]) + row_coef_sum(kern_q[1]) + row_coef_sum(kern_q[2]);
    dneg = -dsum;
    dreq.start    = (state_q == S_CLAMP) && (dsum != '0);
    dreq.dividend = clamped;
    dreq.divisor  = dsum[DsumW-1] ? dneg[MagW-1:0] : dsum[MagW-1:0];
    dreq.negate   = dsum[DsumW-1];
  end

  c3cd_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (acc) state_d = S_READ;
      S_READ:  state_d = fend_q || emit_q ? S_SUM : S_IDLE;
      S_SUM:   if (cnt_q == 2'd2) state_d = S_CLAMP;
      S_CLAMP: state_d = (dsum == '0) ? S_DONE : S_DIV;
      S_DIV:   if (drsp.done) state_d = S_DONE;
      S_DONE:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      emit_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc) begin
        col_q  <= cn[AW-1:0];
        row_q  <= rn;
        emit_q <= emit;
      end
      cnt_q <= (state_q == S_SUM) ? cnt_q + 2'd1 : 2'd0;
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      addr_q <= c1[AW-1:0];
      px_q   <= pixel_i;
      fend_q <= fend && emit;
    end
    if (state_q == S_CLAMP) begin
      res_q <= '0;
      dz_q  <= (dsum == '0);
    end else if (state_q == S_DIV && drsp.done) begin
      res_q <= drsp.quotient;
    end
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_pix_q <= res_q;
      out_dz_q  <= dz_q;
      out_fe_q  <= fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_pix_q;
  assign div_zero_o  = out_dz_q;
  assign frame_end_o = out_fe_q;

`ifndef SYNTHESIS
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE)) else $error("result loaded outside done");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_dz_q |-> out_pix_q == '0) else $error("zero divisor gave nonzero result");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> state_q == S_DIV) else $error("divider finished outside divide step");
  a_sum_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLAMP |-> $past(state_q == S_SUM)) else $error("clamp without full sum chain");
`endif

endmodule
